/* hdl/cau_pkg.sv */
// shared widths, operation codes and item types of the complex arithmetic unit
`timescale 1ns / 1ps
`default_nettype none
package cau_pkg;

  // operand format
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // exact product and sum magnitudes
  localparam int PROD_W = 2 * DATA_WIDTH;

  // quotient bits kept by the divider, one above the result range for overflow
  localparam int QUO_W = DATA_WIDTH + 1;

  // low numerator bits fed into the partial remainder by the divider stages, above them the seed
  localparam int DIV_PRE = QUO_W - FRAC_BITS;

  // front to back queue (power of two)
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // operation codes
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // sign and magnitude value
  typedef struct packed {
    logic              neg;
    logic [PROD_W-1:0] mag;
  } smag_t;

  // classified item handed from front to back
  typedef struct packed {
    op_t               op;
    logic              dz;
    smag_t             re;
    smag_t             im;
    logic [PROD_W-1:0] den;
  } q_entry_t;

  // queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

/* hdl/cau_queue.sv */
// short queue between the front and the back part
`timescale 1ns / 1ps
`default_nettype none
module cau_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  cau_pkg::q_entry_t   din,
  input  wire                 pop,
  output cau_pkg::q_entry_t   dout,
  output cau_pkg::q_status_t  status
);

  cau_pkg::q_entry_t             mem_r [cau_pkg::QDEPTH];
  logic [cau_pkg::QPTR_W-1:0]    wr_ptr_r;
  logic [cau_pkg::QPTR_W-1:0]    rd_ptr_r;
  logic [cau_pkg::QPTR_W:0]      count_r;
  logic [cau_pkg::QPTR_W:0]      count_nxt;

  // status and head
  assign status.full  = (count_r == (cau_pkg::QPTR_W + 1)'(cau_pkg::QDEPTH));
  assign status.empty = (count_r == '0);
  assign dout         = mem_r[rd_ptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule
`default_nettype wire

/* hdl/cau_front.sv */
// front part: accepts items, forms products and classifies them for the back part
`timescale 1ns / 1ps
`default_nettype none
module cau_front (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   start,
  output logic                                  busy,
  input  wire  [1:0]                            in_func,
  input  wire  signed [cau_pkg::DATA_WIDTH-1:0] in_a_re,
  input  wire  signed [cau_pkg::DATA_WIDTH-1:0] in_a_im,
  input  wire  signed [cau_pkg::DATA_WIDTH-1:0] in_b_re,
  input  wire  signed [cau_pkg::DATA_WIDTH-1:0] in_b_im,
  input  cau_pkg::q_status_t                    q_status,
  output logic                                  push,
  output cau_pkg::q_entry_t                     entry
);

  localparam int DW = cau_pkg::DATA_WIDTH;
  localparam int PW = cau_pkg::PROD_W;

  // magnitude of a two's complement word
  function automatic logic [DW-1:0] mag_of(input logic [DW-1:0] x);
    return x[DW-1] ? (~x + 1'b1) : x;
  endfunction

  // exact signed product as sign and magnitude
  function automatic cau_pkg::smag_t mul_sm(input logic [DW-1:0] x, input logic [DW-1:0] y);
    cau_pkg::smag_t r;
    r.mag = PW'(mag_of(x)) * PW'(mag_of(y));
    r.neg = (x[DW-1] ^ y[DW-1]) && (r.mag != '0);
    return r;
  endfunction

  // exact signed sum or difference as sign and magnitude
  function automatic cau_pkg::smag_t addsub_sm(input logic [DW-1:0] x, input logic [DW-1:0] y,
                                               input logic sub);
    cau_pkg::smag_t r;
    logic [DW:0]    s;
    logic [DW:0]    m;
    s = sub ? ({x[DW-1], x} - {y[DW-1], y}) : ({x[DW-1], x} + {y[DW-1], y});
    m = s[DW] ? (~s + 1'b1) : s;
    r.neg = s[DW];
    r.mag = PW'(m);
    return r;
  endfunction

  // signed magnitude addition
  function automatic cau_pkg::smag_t sadd(input cau_pkg::smag_t x, input cau_pkg::smag_t y);
    cau_pkg::smag_t r;
    if (x.neg == y.neg) begin
      r.neg = x.neg;
      r.mag = x.mag + y.mag;
    end else if (x.mag >= y.mag) begin
      r.neg = x.neg;
      r.mag = x.mag - y.mag;
    end else begin
      r.neg = y.neg;
      r.mag = y.mag - x.mag;
    end
    if (r.mag == '0) begin
      r.neg = 1'b0;
    end
    return r;
  endfunction

  function automatic cau_pkg::smag_t sneg(input cau_pkg::smag_t x);
    cau_pkg::smag_t r;
    r     = x;
    r.neg = (x.mag != '0) ? !x.neg : x.neg;
    return r;
  endfunction

  logic           accept;
  logic           prod_v_r;
  cau_pkg::op_t   op_r;
  cau_pkg::smag_t prr_r, pii_r, pri_r, pir_r;
  cau_pkg::smag_t sre_r, sim_r;
  logic [PW-1:0]  drr_r, dii_r;
  cau_pkg::smag_t prr_nxt, pii_nxt, pri_nxt, pir_nxt;
  cau_pkg::smag_t sre_nxt, sim_nxt;
  logic           sub_sel;
  cau_pkg::smag_t mre, mim;
  logic [PW-1:0]  den;

  // handshake: the product stage holds while the queue is full
  assign busy   = prod_v_r && q_status.full;
  assign accept = start && !busy;
  assign push   = prod_v_r && !q_status.full;

  // products and sums of the incoming operands
  always_comb begin
    sub_sel = (cau_pkg::op_t'(in_func) == cau_pkg::OP_SUB);
    prr_nxt = mul_sm(in_a_re, in_b_re);
    pii_nxt = mul_sm(in_a_im, in_b_im);
    pri_nxt = mul_sm(in_a_re, in_b_im);
    pir_nxt = mul_sm(in_a_im, in_b_re);
    sre_nxt = addsub_sm(in_a_re, in_b_re, sub_sel);
    sim_nxt = addsub_sm(in_a_im, in_b_im, sub_sel);
  end

  // product stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else if (accept) begin
      prod_v_r <= 1'b1;
    end else if (push) begin
      prod_v_r <= 1'b0;
    end
  end

  // product stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= cau_pkg::op_t'(in_func);
      prr_r <= prr_nxt;
      pii_r <= pii_nxt;
      pri_r <= pri_nxt;
      pir_r <= pir_nxt;
      sre_r <= sre_nxt;
      sim_r <= sim_nxt;
      drr_r <= PW'(mag_of(in_b_re)) * PW'(mag_of(in_b_re));
      dii_r <= PW'(mag_of(in_b_im)) * PW'(mag_of(in_b_im));
    end
  end

  // classify and combine into a queue entry
  always_comb begin
    den      = drr_r + dii_r;
    mre      = sadd(prr_r, sneg(pii_r));
    mim      = sadd(pri_r, pir_r);
    mre.mag  = mre.mag >> cau_pkg::FRAC_BITS;
    mim.mag  = mim.mag >> cau_pkg::FRAC_BITS;
    if (mre.mag == '0) begin
      mre.neg = 1'b0;
    end
    if (mim.mag == '0) begin
      mim.neg = 1'b0;
    end
    entry.op  = op_r;
    entry.dz  = 1'b0;
    entry.den = den;
    unique case (op_r)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
        entry.re = sre_r;
        entry.im = sim_r;
      end
      cau_pkg::OP_MUL: begin
        entry.re = mre;
        entry.im = mim;
      end
      cau_pkg::OP_DIV: begin
        // numerators of a times the conjugate of b
        entry.dz = (den == '0);
        entry.re = sadd(prr_r, pii_r);
        entry.im = sadd(pir_r, sneg(pri_r));
      end
      default: begin
        entry.re = sre_r;
        entry.im = sim_r;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hdl/cau_back.sv */
// back part: pipelined restoring divider, result selection and saturation
`timescale 1ns / 1ps
`default_nettype none
module cau_back (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  input  cau_pkg::q_entry_t                     entry,
  output logic                                  out_valid,
  output logic signed [cau_pkg::DATA_WIDTH-1:0] out_res_re,
  output logic signed [cau_pkg::DATA_WIDTH-1:0] out_res_im,
  output logic                                  out_div_zero,
  output logic                                  out_saturated
);

  localparam int DW = cau_pkg::DATA_WIDTH;
  localparam int PW = cau_pkg::PROD_W;
  localparam int QW = cau_pkg::QUO_W;
  localparam logic [PW-1:0] HALF = {{(PW-1){1'b0}}, 1'b1} << (DW - 1);

  // one divider lane
  typedef struct packed {
    logic          neg;
    logic [PW-1:0] mag;
    logic [PW-1:0] p;
    logic [QW-1:0] q;
    logic          ovf;
  } lane_t;

  typedef struct packed {
    cau_pkg::op_t  op;
    logic          dz;
    logic [PW-1:0] den;
    lane_t         re;
    lane_t         im;
  } stage_t;

  typedef struct packed {
    logic          sat;
    logic [DW-1:0] val;
  } clamp_t;

  // seed the partial remainder and test for quotient overflow
  function automatic lane_t init_lane(input cau_pkg::smag_t n, input logic [PW-1:0] d);
    lane_t l;
    l.neg = n.neg;
    l.mag = n.mag;
    l.p   = n.mag >> cau_pkg::DIV_PRE;
    l.q   = '0;
    l.ovf = ((n.mag >> cau_pkg::DIV_PRE) >= d);
    return l;
  endfunction

  // one quotient bit
  function automatic lane_t div_step(input lane_t l, input logic [PW-1:0] d, input logic nbit);
    lane_t      r;
    logic [PW:0] t;
    logic [PW:0] diff;
    r    = l;
    t    = {l.p, nbit};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      r.p = diff[PW-1:0];
      r.q = {l.q[QW-2:0], 1'b1};
    end else begin
      r.p = t[PW-1:0];
      r.q = {l.q[QW-2:0], 1'b0};
    end
    return r;
  endfunction

  // pick the final magnitude and clamp to the result range
  function automatic clamp_t finish(input lane_t l, input cau_pkg::op_t op, input logic dz);
    clamp_t        c;
    logic          neg;
    logic [PW-1:0] m;
    logic [PW-1:0] lim;
    neg = l.neg;
    m   = l.mag;
    if (op == cau_pkg::OP_DIV) begin
      if (dz) begin
        neg = 1'b0;
        m   = '0;
      end else if (l.ovf) begin
        m = HALF + 1'b1;
      end else begin
        m = PW'(l.q);
      end
    end
    lim   = neg ? HALF : (HALF - 1'b1);
    c.sat = (m > lim);
    if (c.sat) begin
      m = lim;
    end
    c.val = neg ? (~m[DW-1:0] + 1'b1) : m[DW-1:0];
    return c;
  endfunction

  stage_t st_r [QW+1];
  logic [QW:0] vld_r;
  clamp_t cre, cim;
  logic   out_valid_r;
  logic signed [DW-1:0] res_re_r, res_im_r;
  logic   dz_r, sat_r;

  // valid bits along the divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[QW-1:0], in_valid};
      out_valid_r <= vld_r[QW];
    end
  end

  // entry into the divider
  always_ff @(posedge clk) begin
    st_r[0].op  <= entry.op;
    st_r[0].dz  <= entry.dz;
    st_r[0].den <= entry.den;
    st_r[0].re  <= init_lane(entry.re, entry.den);
    st_r[0].im  <= init_lane(entry.im, entry.den);
  end

  // divider stages, most significant quotient bit first
  for (genvar s = 0; s < QW; s++) begin : g_div
    localparam int K = QW - 1 - s;
    logic nbit_re;
    logic nbit_im;
    if (K >= cau_pkg::FRAC_BITS) begin : g_bit
      assign nbit_re = st_r[s].re.mag[K-cau_pkg::FRAC_BITS];
      assign nbit_im = st_r[s].im.mag[K-cau_pkg::FRAC_BITS];
    end else begin : g_zero
      assign nbit_re = 1'b0;
      assign nbit_im = 1'b0;
    end
    always_ff @(posedge clk) begin
      st_r[s+1].op  <= st_r[s].op;
      st_r[s+1].dz  <= st_r[s].dz;
      st_r[s+1].den <= st_r[s].den;
      st_r[s+1].re  <= div_step(st_r[s].re, st_r[s].den, nbit_re);
      st_r[s+1].im  <= div_step(st_r[s].im, st_r[s].den, nbit_im);
    end
  end

  // saturation and output register
  always_comb begin
    cre = finish(st_r[QW].re, st_r[QW].op, st_r[QW].dz);
    cim = finish(st_r[QW].im, st_r[QW].op, st_r[QW].dz);
  end

  always_ff @(posedge clk) begin
    res_re_r <= cre.val;
    res_im_r <= cim.val;
    dz_r     <= (st_r[QW].op == cau_pkg::OP_DIV) && st_r[QW].dz;
    sat_r    <= cre.sat || cim.sat;
  end

  assign out_valid     = out_valid_r;
  assign out_res_re    = res_re_r;
  assign out_res_im    = res_im_r;
  assign out_div_zero  = dz_r;
  assign out_saturated = sat_r;

endmodule
`default_nettype wire

/* hdl/complex_arith_unit.sv */
// complex add, subtract, multiply and divide in signed Q16.16 with saturation
// every operation passes the product stage, queue, divider and output register
// throughput: one item per cycle, set by the 33-stage pipelined quotient divider
// busy is high only while the product stage holds on a full front-to-back queue
// the receiver cannot stall, so busy stays low in operation
// reset (synchronous, rst_n low) clears all valid bits and queue pointers
`timescale 1ns / 1ps
`default_nettype none
module complex_arith_unit (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   start,
  output logic                                  busy,
  input  wire  [1:0]                            in_func,
  input  wire  signed [cau_pkg::DATA_WIDTH-1:0] in_a_re,
  input  wire  signed [cau_pkg::DATA_WIDTH-1:0] in_a_im,
  input  wire  signed [cau_pkg::DATA_WIDTH-1:0] in_b_re,
  input  wire  signed [cau_pkg::DATA_WIDTH-1:0] in_b_im,
  output logic                                  out_valid,
  output logic signed [cau_pkg::DATA_WIDTH-1:0] out_res_re,
  output logic signed [cau_pkg::DATA_WIDTH-1:0] out_res_im,
  output logic                                  out_div_zero,
  output logic                                  out_saturated
);

  cau_pkg::q_entry_t  f_entry;
  cau_pkg::q_entry_t  q_head;
  cau_pkg::q_status_t q_status;
  logic               q_push;
  logic               q_pop;

  // the back part takes an entry whenever one is waiting
  assign q_pop = !q_status.empty;

  cau_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_func  (in_func),
    .in_a_re  (in_a_re),
    .in_a_im  (in_a_im),
    .in_b_re  (in_b_re),
    .in_b_im  (in_b_im),
    .q_status (q_status),
    .push     (q_push),
    .entry    (f_entry)
  );

  cau_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .din    (f_entry),
    .pop    (q_pop),
    .dout   (q_head),
    .status (q_status)
  );

  cau_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (q_pop),
    .entry         (q_head),
    .out_valid     (out_valid),
    .out_res_re    (out_res_re),
    .out_res_im    (out_res_im),
    .out_div_zero  (out_div_zero),
    .out_saturated (out_saturated)
  );

endmodule
`default_nettype wire

/* verif/tb.sv */
// self-checking testbench for the complex arithmetic unit
`timescale 1ns / 1ps
module tb;

  typedef logic [63:0] u64;

  typedef struct {
    logic neg;
    u64   mag;
  } sgn_mag_t;

  typedef struct {
    cau_pkg::op_t      op;
    logic signed [31:0] a_re, a_im, b_re, b_im;
    bit                 wait_drain;
  } cmd_t;

  typedef struct {
    logic signed [31:0] re, im;
    logic               dz, sat;
  } cplx_res_t;

  localparam int FB = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_func = '0;
  logic signed [31:0] in_a_re = '0, in_a_im = '0, in_b_re = '0, in_b_im = '0;
  logic out_valid;
  logic signed [31:0] out_res_re, out_res_im;
  logic out_div_zero, out_saturated;

  cmd_t      cmd_q[$];
  cplx_res_t want_q[$];
  int        errors = 0;
  int        gap = 0;
  int        op_count[4] = '{0, 0, 0, 0};
  int        dz_count = 0, sat_count = 0, checked = 0;

  complex_arith_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_a_re(in_a_re), .in_a_im(in_a_im),
    .in_b_re(in_b_re), .in_b_im(in_b_im),
    .out_valid(out_valid), .out_res_re(out_res_re), .out_res_im(out_res_im),
    .out_div_zero(out_div_zero), .out_saturated(out_saturated)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // signed magnitude helpers
  function automatic sgn_mag_t sm_of(longint x);
    sgn_mag_t r;
    r.neg = x < 0;
    r.mag = x < 0 ? u64'(-x) : u64'(x);
    return r;
  endfunction

  function automatic sgn_mag_t sm_mul(longint x, longint y);
    sgn_mag_t r, p, q;
    p = sm_of(x);
    q = sm_of(y);
    r.mag = p.mag * q.mag;
    r.neg = (p.neg != q.neg) && r.mag != 0;
    return r;
  endfunction

  function automatic sgn_mag_t sm_add(sgn_mag_t x, sgn_mag_t y);
    sgn_mag_t r;
    if (x.neg == y.neg) begin
      r.neg = x.neg;
      r.mag = x.mag + y.mag;
    end else if (x.mag >= y.mag) begin
      r.neg = x.neg;
      r.mag = x.mag - y.mag;
    end else begin
      r.neg = y.neg;
      r.mag = y.mag - x.mag;
    end
    if (r.mag == 0) r.neg = 1'b0;
    return r;
  endfunction

  function automatic sgn_mag_t sm_neg(sgn_mag_t x);
    if (x.mag != 0) x.neg = !x.neg;
    return x;
  endfunction

  function automatic u64 limit_for(logic neg);
    return neg ? u64'(64'h8000_0000) : u64'(64'h7fff_ffff);
  endfunction

  function automatic logic [31:0] clamp32(sgn_mag_t v, inout logic sat);
    u64 m;
    m = v.mag;
    if (m > limit_for(v.neg)) begin
      m = limit_for(v.neg);
      sat = 1'b1;
    end
    return v.neg ? 32'(-m) : 32'(m);
  endfunction

  // restoring quotient scaled by the fraction bits, capped just over the limit
  function automatic sgn_mag_t frac_quot(sgn_mag_t num, u64 den);
    sgn_mag_t r;
    u64 lim, q, rem;
    lim = limit_for(num.neg);
    q = num.mag / den;
    rem = num.mag % den;
    r.neg = num.neg;
    if (q > lim) begin
      r.mag = lim + 1;
      return r;
    end
    for (int i = 0; i < FB; i++) begin
      if (rem >= den - rem) begin
        rem = rem - (den - rem);
        q = q * 2 + 1;
      end else begin
        rem = rem * 2;
        q = q * 2;
      end
      if (q > lim) begin
        r.mag = lim + 1;
        return r;
      end
    end
    r.mag = q;
    if (q == 0) r.neg = 1'b0;
    return r;
  endfunction

  function automatic cplx_res_t cplx_eval(cmd_t c);
    cplx_res_t o;
    sgn_mag_t re, im;
    sgn_mag_t sq_re, sq_im;
    longint ar, ai, br, bi;
    u64 den;
    ar = c.a_re;
    ai = c.a_im;
    br = c.b_re;
    bi = c.b_im;
    o.dz = 1'b0;
    o.sat = 1'b0;
    case (c.op)
      cau_pkg::OP_ADD: begin
        re = sm_of(ar + br);
        im = sm_of(ai + bi);
      end
      cau_pkg::OP_SUB: begin
        re = sm_of(ar - br);
        im = sm_of(ai - bi);
      end
      cau_pkg::OP_MUL: begin
        re = sm_add(sm_mul(ar, br), sm_neg(sm_mul(ai, bi)));
        im = sm_add(sm_mul(ar, bi), sm_mul(ai, br));
        re.mag = re.mag >> FB;
        im.mag = im.mag >> FB;
        if (re.mag == 0) re.neg = 1'b0;
        if (im.mag == 0) im.neg = 1'b0;
      end
      default: begin
        sq_re = sm_mul(br, br);
        sq_im = sm_mul(bi, bi);
        den = sq_re.mag + sq_im.mag;
        if (den == 0) begin
          o.dz = 1'b1;
          re = '{1'b0, 0};
          im = '{1'b0, 0};
        end else begin
          re = frac_quot(sm_add(sm_mul(ar, br), sm_mul(ai, bi)), den);
          im = frac_quot(sm_add(sm_mul(ai, br), sm_neg(sm_mul(ar, bi))), den);
        end
      end
    endcase
    o.re = clamp32(re, o.sat);
    o.im = clamp32(im, o.sat);
    return o;
  endfunction

  // operand mix: full range, small, zero and extremes
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 6))
      0, 1: return $urandom;
      2: return 32'($signed(18'($urandom)));
      3: return 32'($signed(22'($urandom)));
      4: return '0;
      5: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0001_0000;
          3: return 32'hffff_ffff;
          default: return 32'h0000_0001;
        endcase
      end
      default: return 32'($signed(26'($urandom)));
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic add_cmd(cau_pkg::op_t op, logic [31:0] ar, logic [31:0] ai,
                         logic [31:0] br, logic [31:0] bi, bit hold);
    cmd_t c;
    c.op = op;
    c.a_re = ar;
    c.a_im = ai;
    c.b_re = br;
    c.b_im = bi;
    c.wait_drain = hold;
    cmd_q.push_back(c);
  endtask

  // driver: one transfer per edge with start high and busy low
  always @(posedge clk) begin
    cmd_t c;
    bit   take;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      take = 1'b1;
      if (start && !busy) begin
        c.op = cau_pkg::op_t'(in_func);
        c.a_re = in_a_re;
        c.a_im = in_a_im;
        c.b_re = in_b_re;
        c.b_im = in_b_im;
        want_q.push_back(cplx_eval(c));
        op_count[in_func]++;
      end else if (start) begin
        take = 1'b0;
      end
      if (take) begin
        if (gap > 0) begin
          gap--;
          start <= 1'b0;
        end else if (cmd_q.size() > 0 &&
                     (!cmd_q[0].wait_drain || (want_q.size() == 0 && !start))) begin
          c = cmd_q.pop_front();
          in_func <= c.op;
          in_a_re <= c.a_re;
          in_a_im <= c.a_im;
          in_b_re <= c.b_re;
          in_b_im <= c.b_im;
          start <= 1'b1;
          gap = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    cplx_res_t w;
    if (rst_n && out_valid) begin
      if (want_q.size() == 0) begin
        $error("unexpected result re=%h im=%h", out_res_re, out_res_im);
        errors++;
      end else begin
        w = want_q.pop_front();
        checked++;
        if (w.dz) dz_count++;
        if (w.sat) sat_count++;
        if (out_res_re !== w.re) begin
          $error("res_re expected %h actual %h", w.re, out_res_re);
          errors++;
        end
        if (out_res_im !== w.im) begin
          $error("res_im expected %h actual %h", w.im, out_res_im);
          errors++;
        end
        if (out_div_zero !== w.dz) begin
          $error("div_zero expected %b actual %b", w.dz, out_div_zero);
          errors++;
        end
        if (out_saturated !== w.sat) begin
          $error("saturated expected %b actual %b", w.sat, out_saturated);
          errors++;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    cau_pkg::op_t op;
    // directed: extremes, each operation, zero divisor, real minus complex
    add_cmd(cau_pkg::OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff, 0);
    add_cmd(cau_pkg::OP_ADD, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0);
    add_cmd(cau_pkg::OP_ADD, 32'h0001_0000, 32'h0002_0000, 32'hffff_0000, 32'h0, 0);
    add_cmd(cau_pkg::OP_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff, 0);
    add_cmd(cau_pkg::OP_SUB, 32'h0003_0000, 32'h0, 32'h0001_0000, 32'h0002_8000, 0);
    add_cmd(cau_pkg::OP_SUB, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 0);
    add_cmd(cau_pkg::OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hffff_0000, 0);
    add_cmd(cau_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    add_cmd(cau_pkg::OP_MUL, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff, 32'h0, 0);
    add_cmd(cau_pkg::OP_MUL, 32'hffff_ffff, 32'h0, 32'h0000_0001, 32'h0, 0);
    add_cmd(cau_pkg::OP_MUL, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'hffff_ffff, 0);
    add_cmd(cau_pkg::OP_DIV, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 0);
    add_cmd(cau_pkg::OP_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0, 0);
    add_cmd(cau_pkg::OP_DIV, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'h0, 0);
    add_cmd(cau_pkg::OP_DIV, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'hffff_0000, 0);
    add_cmd(cau_pkg::OP_DIV, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0001, 32'h0, 0);
    add_cmd(cau_pkg::OP_DIV, 32'h8000_0000, 32'h0, 32'h0000_0001, 32'h0000_0001, 0);
    add_cmd(cau_pkg::OP_DIV, 32'h0000_0001, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0);
    add_cmd(cau_pkg::OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    add_cmd(cau_pkg::OP_DIV, 32'hffff_ffff, 32'h0, 32'h0000_0002, 32'h0, 1);
    // random part, with a few points where the sender waits for a full drain
    for (int i = 0; i < 1330; i++) begin
      op = cau_pkg::op_t'($urandom_range(0, 3));
      add_cmd(op, pick_operand(), pick_operand(),
              ($urandom_range(0, 15) == 0) ? 32'h0 : pick_operand(),
              ($urandom_range(0, 7) == 0) ? 32'h0 : pick_operand(),
              (i % 400) == 399);
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (cmd_q.size() > 0 || start || want_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("checked %0d results: add %0d sub %0d mul %0d div %0d", checked,
             op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("zero divisor cases %0d, saturated results %0d", dz_count, sat_count);
    if (errors == 0 && want_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* complex_arith_unit.f */
hdl/cau_pkg.sv
hdl/cau_queue.sv
hdl/cau_front.sv
hdl/cau_back.sv
hdl/complex_arith_unit.sv
verif/tb.sv
